>>> src/websocket_frame_encoder_macros.svh
// Assertion macros shared by the frame encoder modules.
`ifndef WEBSOCKET_FRAME_ENCODER_MACROS_SVH
`define WEBSOCKET_FRAME_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define WSFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define WSFE_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`else

`define WSFE_ASSERT(label, prop, msg)

`define WSFE_ASSERT_NEVER(label, expr, msg)

`endif

`endif

>>> src/wsfe_pkg.sv
// Types and constants of the WebSocket frame encoder.
package wsfe_pkg;

    localparam int unsigned WSFE_QUEUE_DEPTH = 4;

    localparam logic        ACT_HEADER    = 1'b0;
    localparam logic        ACT_PAYLOAD   = 1'b1;

    localparam logic [31:0] MAX_LEN_RESET = 32'hFFFF_FFFF;
    localparam logic [31:0] LEN7_LIMIT    = 32'd126;
    localparam logic [31:0] LEN16_LIMIT   = 32'd65536;
    localparam logic [7:0]  LEN_BYTE_16   = 8'd126;
    localparam logic [7:0]  LEN_BYTE_64   = 8'd127;
    localparam logic [3:0]  HLEN_7        = 4'd2;
    localparam logic [3:0]  HLEN_16       = 4'd4;
    localparam logic [3:0]  HLEN_64       = 4'd10;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MASK     = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_NO_FRAME = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        LEN_7  = 2'd0,
        LEN_16 = 2'd1,
        LEN_64 = 2'd2
    } t_len_code;

    typedef struct packed {
        logic        action;
        logic        fin;
        logic [2:0]  rsv;
        logic [3:0]  opcode;
        logic        mask_request;
        logic [31:0] payload_length;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        t_status     status;
        logic [32:0] frame_length;
    } t_out_item;

    // One queued command: either a header to expand or a single result beat.
    typedef struct packed {
        logic        hdr;
        logic [7:0]  byte0;
        logic [31:0] plen;
        t_len_code   len_code;
        logic [32:0] flen;
        t_status     status;
        logic        last;
    } t_cmd;

endpackage

>>> src/wsfe_front.sv
// Front end: accepts items, checks them against the frame state and issues commands.
module wsfe_front
    import wsfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_item    i_item,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    output t_cmd        o_cmd
);

`include "websocket_frame_encoder_macros.svh"

    logic [31:0] r_max;
    logic [31:0] r_rem;
    logic        r_open;
    logic [32:0] r_cur;
    logic [31:0] n_rem;
    logic        n_open;
    logic [32:0] n_cur;

    t_len_code   code;
    logic [3:0]  hlen;
    logic [32:0] total;

    always_comb begin
        if (i_item.payload_length < LEN7_LIMIT) begin
            code = LEN_7;
            hlen = HLEN_7;
        end else if (i_item.payload_length < LEN16_LIMIT) begin
            code = LEN_16;
            hlen = HLEN_16;
        end else begin
            code = LEN_64;
            hlen = HLEN_64;
        end
        total = {1'b0, i_item.payload_length} + 33'(hlen);
    end

    always_comb begin
        n_rem  = r_rem;
        n_open = r_open;
        n_cur  = r_cur;
        o_cmd  = '0;
        if (i_item.action == ACT_HEADER) begin
            n_rem  = '0;
            n_open = 1'b0;
            n_cur  = '0;
            if (i_item.mask_request) begin
                o_cmd.status = ST_MASK;
            end else if (total > {1'b0, r_max}) begin
                o_cmd.status = ST_TOO_LONG;
                o_cmd.flen   = total;
            end else begin
                o_cmd.hdr      = 1'b1;
                o_cmd.byte0    = {i_item.fin, i_item.rsv, i_item.opcode};
                o_cmd.plen     = i_item.payload_length;
                o_cmd.len_code = code;
                o_cmd.flen     = total;
                o_cmd.status   = ST_OK;
                o_cmd.last     = (i_item.payload_length == '0);
                n_cur          = total;
                n_rem          = i_item.payload_length;
                n_open         = (i_item.payload_length != '0);
            end
        end else if (!r_open || r_rem == '0) begin
            o_cmd.status = ST_NO_FRAME;
        end else begin
            n_rem        = r_rem - 32'd1;
            n_open       = (r_rem != 32'd1);
            o_cmd.byte0  = i_item.data_byte;
            o_cmd.last   = (r_rem == 32'd1);
            o_cmd.flen   = r_cur;
            o_cmd.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= MAX_LEN_RESET;
            r_rem  <= '0;
            r_open <= 1'b0;
            r_cur  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            if (i_accept) begin
                r_rem  <= n_rem;
                r_open <= n_open;
                r_cur  <= n_cur;
            end
        end
    end

    `WSFE_ASSERT(a_open_has_bytes, r_open |-> (r_rem != '0), "open frame with no payload left")
    `WSFE_ASSERT_NEVER(a_closed_no_len, !r_open && (r_rem != '0), "payload left on a closed frame")
    `WSFE_ASSERT(a_open_len, r_open |-> (r_cur > {1'b0, r_rem}), "frame length below remaining payload")

endmodule

>>> src/wsfe_queue.sv
// Short command queue between the front end and the byte emitter.
module wsfe_queue
    import wsfe_pkg::*;
#(
    parameter int unsigned DEPTH = WSFE_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_full,
    output logic o_empty
);

`include "websocket_frame_encoder_macros.svh"

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `WSFE_ASSERT_NEVER(a_cnt_range, r_cnt > CW'(DEPTH), "queue count beyond depth")
    `WSFE_ASSERT(a_ptr_match, (r_cnt == '0) |-> (r_wr == r_rd), "pointers differ on an empty queue")

endmodule

>>> src/wsfe_back.sv
// Back end: expands queued commands into frame bytes and holds the result register.
module wsfe_back
    import wsfe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_empty,
    output logic      o_cmd_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

`include "websocket_frame_encoder_macros.svh"

    logic       r_valid;
    t_out_item  r_out;
    logic [3:0] r_idx;
    logic [3:0] n_idx;
    logic [3:0] hlen_m1;
    logic       final_beat;
    logic       load;
    logic [7:0] hdr_byte;
    t_out_item  n_out;

    always_comb begin
        unique case (i_cmd.len_code)
            LEN_7:   hlen_m1 = HLEN_7 - 4'd1;
            LEN_16:  hlen_m1 = HLEN_16 - 4'd1;
            default: hlen_m1 = HLEN_64 - 4'd1;
        endcase
    end

    always_comb begin
        hdr_byte = '0;
        if (r_idx == '0) begin
            hdr_byte = i_cmd.byte0;
        end else begin
            unique case (i_cmd.len_code)
                LEN_7: begin
                    hdr_byte = {1'b0, i_cmd.plen[6:0]};
                end
                LEN_16: begin
                    unique case (r_idx)
                        4'd1:    hdr_byte = LEN_BYTE_16;
                        4'd2:    hdr_byte = i_cmd.plen[15:8];
                        default: hdr_byte = i_cmd.plen[7:0];
                    endcase
                end
                default: begin
                    unique case (r_idx)
                        4'd1:    hdr_byte = LEN_BYTE_64;
                        4'd6:    hdr_byte = i_cmd.plen[31:24];
                        4'd7:    hdr_byte = i_cmd.plen[23:16];
                        4'd8:    hdr_byte = i_cmd.plen[15:8];
                        4'd9:    hdr_byte = i_cmd.plen[7:0];
                        default: hdr_byte = '0;
                    endcase
                end
            endcase
        end
    end

    assign final_beat = !i_cmd.hdr || (r_idx == hlen_m1);
    assign load       = !i_cmd_empty && (!r_valid || i_pop);
    assign o_cmd_pop  = load && final_beat;
    assign n_idx      = final_beat ? '0 : r_idx + 4'd1;

    always_comb begin
        n_out.frame_length = i_cmd.flen;
        n_out.status       = i_cmd.status;
        if (i_cmd.hdr) begin
            n_out.out_byte   = hdr_byte;
            n_out.byte_valid = 1'b1;
            n_out.last       = i_cmd.last && final_beat;
        end else begin
            n_out.out_byte   = i_cmd.byte0;
            n_out.byte_valid = (i_cmd.status == ST_OK);
            n_out.last       = i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= n_idx;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_empty = !r_valid;
    assign o_item  = r_out;

    `WSFE_ASSERT_NEVER(a_idx_range, r_idx > HLEN_64 - 4'd1, "header beat index out of range")
    `WSFE_ASSERT(a_idx_cmd, (r_idx != '0) |-> (!i_cmd_empty && i_cmd.hdr), "header lost mid-expansion")
    `WSFE_ASSERT(a_err_beat, (r_valid && !r_out.byte_valid) |-> (r_out.status != ST_OK), "invalid beat with ok status")

endmodule

>>> src/websocket_frame_encoder.sv
// Unmasked WebSocket frame encoder top level.
// An accepted item is queued, then its beats pass through the output register.
// Payload and error items give one beat each; a header gives 2, 4 or 10 beats.
// Items are taken at one per cycle while the four-entry command queue has room.
// Synchronous active-low reset empties the queue and output, closes any frame and
// sets the maximum frame length to all ones.
module websocket_frame_encoder
    import wsfe_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = WSFE_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    wsfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_cmd      (front_cmd)
    );

    wsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .i_pop   (q_pop),
        .o_data  (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    wsfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out_item)
    );

endmodule

>>> tb/websocket_frame_encoder_tb.sv
// Self-checking testbench for the unmasked WebSocket frame encoder.

class frame_checker;
    logic [31:0] max_len;
    logic [31:0] bytes_left;
    logic        in_frame;
    logic [32:0] frame_len;
    wsfe_pkg::t_out_item expected_beats[$];
    int mismatches;

    function new();
        max_len    = wsfe_pkg::MAX_LEN_RESET;
        bytes_left = '0;
        in_frame   = 1'b0;
        frame_len  = '0;
        mismatches = 0;
    endfunction

    function int pending();
        return expected_beats.size();
    endfunction

    function void add_beat(logic [7:0] b, logic valid, logic lst, wsfe_pkg::t_status st,
                           logic [32:0] flen);
        wsfe_pkg::t_out_item beat;
        beat.out_byte     = b;
        beat.byte_valid   = valid;
        beat.last         = lst;
        beat.status       = st;
        beat.frame_length = flen;
        expected_beats.push_back(beat);
    endfunction

    function void note_item(wsfe_pkg::t_in_item it);
        logic [7:0]  hdr [10];
        int          hlen;
        logic [32:0] total;
        logic [31:0] plen;
        plen = it.payload_length;
        if (it.action == wsfe_pkg::ACT_HEADER) begin
            in_frame   = 1'b0;
            bytes_left = '0;
            frame_len  = '0;
            if (it.mask_request) begin
                add_beat(8'h00, 1'b0, 1'b0, wsfe_pkg::ST_MASK, 33'd0);
                return;
            end
            hdr[0] = {it.fin, it.rsv, it.opcode};
            if (plen < wsfe_pkg::LEN7_LIMIT) begin
                hdr[1] = plen[7:0];
                hlen   = wsfe_pkg::HLEN_7;
            end else if (plen < wsfe_pkg::LEN16_LIMIT) begin
                hdr[1] = wsfe_pkg::LEN_BYTE_16;
                hdr[2] = plen[15:8];
                hdr[3] = plen[7:0];
                hlen   = wsfe_pkg::HLEN_16;
            end else begin
                hdr[1] = wsfe_pkg::LEN_BYTE_64;
                hdr[2] = 8'h00;
                hdr[3] = 8'h00;
                hdr[4] = 8'h00;
                hdr[5] = 8'h00;
                hdr[6] = plen[31:24];
                hdr[7] = plen[23:16];
                hdr[8] = plen[15:8];
                hdr[9] = plen[7:0];
                hlen   = wsfe_pkg::HLEN_64;
            end
            total = 33'(hlen) + {1'b0, plen};
            if (total > {1'b0, max_len}) begin
                add_beat(8'h00, 1'b0, 1'b0, wsfe_pkg::ST_TOO_LONG, total);
                return;
            end
            for (int i = 0; i < hlen; i++) begin
                add_beat(hdr[i], 1'b1, (i == hlen - 1) && (plen == 0), wsfe_pkg::ST_OK, total);
            end
            frame_len  = total;
            bytes_left = plen;
            in_frame   = (plen != 0);
        end else begin
            if (!in_frame || bytes_left == 0) begin
                add_beat(8'h00, 1'b0, 1'b0, wsfe_pkg::ST_NO_FRAME, 33'd0);
                return;
            end
            bytes_left = bytes_left - 1;
            add_beat(it.data_byte, 1'b1, bytes_left == 0, wsfe_pkg::ST_OK, frame_len);
            if (bytes_left == 0) begin
                in_frame = 1'b0;
            end
        end
    endfunction

    function void check_beat(wsfe_pkg::t_out_item got);
        wsfe_pkg::t_out_item want;
        if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected beat: byte %h valid %b last %b status %0d len %h",
                         got.out_byte, got.byte_valid, got.last, got.status, got.frame_length);
            end
            return;
        end
        want = expected_beats.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
            got.last !== want.last || got.status !== want.status ||
            got.frame_length !== want.frame_length) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("beat mismatch at %0t: expected byte %h valid %b last %b status %0d len %h",
                         $realtime, want.out_byte, want.byte_valid, want.last, want.status,
                         want.frame_length);
                $display("                         got byte %h valid %b last %b status %0d len %h",
                         got.out_byte, got.byte_valid, got.last, got.status, got.frame_length);
            end
        end
    endfunction
endclass

module websocket_frame_encoder_tb;
    import wsfe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    in_item;
    logic        empty;
    logic        pop;
    t_out_item   out_item;
    logic        cfg_we;
    logic [31:0] cfg_data;

    frame_checker sb = new();
    int items_sent = 0;
    int pop_hold   = 0;
    bit quiet      = 1'b0;

    websocket_frame_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                sb.note_item(in_item);
            end
            if (pop && !empty) begin
                sb.check_beat(out_item);
            end
        end
    end

    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            pop_hold = $urandom_range(1, 16) - 1;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic send_item(t_in_item it);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        push    <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (full);
        items_sent++;
    endtask

    task automatic send_header(logic fin, logic [2:0] rsv, logic [3:0] opc, logic mask,
                               logic [31:0] plen);
        t_in_item it;
        it.action         = ACT_HEADER;
        it.fin            = fin;
        it.rsv            = rsv;
        it.opcode         = opc;
        it.mask_request   = mask;
        it.payload_length = plen;
        it.data_byte      = 8'($urandom);
        send_item(it);
    endtask

    task automatic send_payload(logic [7:0] b);
        t_in_item it;
        it                = t_in_item'({$urandom, $urandom});
        it.action         = ACT_PAYLOAD;
        it.data_byte      = b;
        send_item(it);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_max(logic [31:0] value);
        wait_drained();
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        sb.max_len = value;
    endtask

    task automatic random_frame();
        int unsigned pick;
        int unsigned nbytes;
        logic [31:0] plen;
        longint      near;
        int          hl;
        int          off;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_payload(8'($urandom));
            return;
        end
        if (pick < 14) begin
            send_header(1'($urandom), 3'($urandom), 4'($urandom), 1'b1, $urandom);
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            plen = $urandom_range(0, 12);
        end else if (pick < 65) begin
            plen = $urandom_range(13, 125);
        end else if (pick < 78) begin
            plen = $urandom_range(126, 140);
        end else if (pick < 88) begin
            case ($urandom_range(0, 2))
                0: hl = HLEN_7;
                1: hl = HLEN_16;
                default: hl = HLEN_64;
            endcase
            off  = int'($urandom_range(0, 2)) - 1;
            near = longint'(sb.max_len) - hl + off;
            if (near < 0) begin
                near = 0;
            end
            if (near > 64'hFFFF_FFFF) begin
                near = 64'hFFFF_FFFF;
            end
            plen = near[31:0];
        end else if (pick < 94) begin
            plen = $urandom_range(141, 65540);
        end else begin
            plen = $urandom;
        end
        send_header(1'($urandom), 3'($urandom), 4'($urandom), 1'b0, plen);
        if (plen <= 20 || (plen <= 140 && $urandom_range(0, 3) == 0)) begin
            nbytes = plen;
        end else begin
            nbytes = $urandom_range(0, 4);
        end
        if ($urandom_range(0, 9) == 0) begin
            nbytes = nbytes + 1;
        end
        repeat (nbytes) send_payload(8'($urandom));
    endtask

    initial begin
        i_rst_n  = 1'b0;
        push     = 1'b0;
        in_item  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_header(1'b1, 3'd7, 4'hF, 1'b0, 32'd0);
        send_header(1'b0, 3'd0, 4'h0, 1'b0, 32'd3);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'h5A);
        send_payload(8'hC3);
        send_header(1'b1, 3'd2, 4'h1, 1'b1, 32'd5);
        send_header(1'b1, 3'd1, 4'h2, 1'b0, 32'd125);
        send_payload(8'h81);
        send_header(1'b0, 3'd4, 4'h8, 1'b0, 32'd126);
        send_header(1'b1, 3'd3, 4'h9, 1'b0, 32'd65535);
        send_header(1'b0, 3'd6, 4'hA, 1'b0, 32'd65536);
        send_payload(8'h7E);
        send_header(1'b1, 3'd5, 4'h3, 1'b1, 32'hFFFF_FFFF);
        send_payload(8'h3C);
        send_header(1'b1, 3'd0, 4'h2, 1'b0, 32'hFFFF_FFFF);
        send_header(1'b0, 3'd7, 4'h0, 1'b0, 32'hFFFF_FFF5);
        send_header(1'b1, 3'd1, 4'h1, 1'b0, 32'hFFFF_FFF6);
        send_header(1'b1, 3'd5, 4'hA, 1'b0, 32'd1);
        send_payload(8'h80);
        send_payload(8'h01);
        send_header(1'b0, 3'd2, 4'h4, 1'b0, 32'hA5A5_5A5A);
        send_payload(8'hE7);

        while (items_sent < 100) random_frame();
        write_max(32'd0);
        while (items_sent < 160) random_frame();
        write_max(32'd12);
        while (items_sent < 240) random_frame();
        write_max(32'd140);
        while (items_sent < 310) random_frame();
        write_max($urandom);
        while (items_sent < 360) random_frame();
        write_max(32'd70000);
        while (items_sent < 420) random_frame();
        wait_drained();
        quiet = 1'b1;
        write_max(MAX_LEN_RESET);
        while (items_sent < 480) random_frame();

        wait_drained();
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+src
src/wsfe_pkg.sv
src/wsfe_front.sv
src/wsfe_queue.sv
src/wsfe_back.sv
src/websocket_frame_encoder.sv
tb/websocket_frame_encoder_tb.sv
